[rtl/target_window_selector_unit_defines.svh]
// Assertion macros for the target window selector.
// Expanded inside the top level, which supplies i_clk and i_rst_n.
`ifndef TARGET_WINDOW_SELECTOR_UNIT_DEFINES_SVH
`define TARGET_WINDOW_SELECTOR_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define TWS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define TWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tws_pkg.sv]
// Package for the target window selector: word types, register indexes,
// spin codes and reset values. No dependencies.
package tws_pkg;

    localparam int ANGLE_W = 16;
    localparam int WIN_W   = 15;
    localparam int ID_W    = 8;
    localparam int POS_W   = 4;
    localparam int SPIN_W  = 2;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_CANDIDATES_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COMING          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVING         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPOST_COMING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPOST_LEAVING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MARGIN   = 3'd4;

    // Reset values in binary angle units (pi per 32768).
    localparam logic [WIN_W-1:0] COMING_RST          = 15'd10923;
    localparam logic [WIN_W-1:0] LEAVING_RST         = 15'd3641;
    localparam logic [WIN_W-1:0] OUTPOST_COMING_RST  = 15'd12743;
    localparam logic [WIN_W-1:0] OUTPOST_LEAVING_RST = 15'd5461;
    localparam logic [WIN_W-1:0] SWITCH_MARGIN_RST   = 15'd1456;

    // Spin sign codes; the unused code behaves as zero spin.
    localparam logic [SPIN_W-1:0] SPIN_ZERO = 2'd0;
    localparam logic [SPIN_W-1:0] SPIN_POS  = 2'd1;
    localparam logic [SPIN_W-1:0] SPIN_NEG  = 2'd2;

    typedef struct packed {
        logic                      first_of_set;
        logic                      last_of_set;
        logic                      outpost_flag;
        logic signed [ANGLE_W-1:0] plate_yaw;
        logic signed [ANGLE_W-1:0] hub_yaw;
        logic [SPIN_W-1:0]         spin_sign;
        logic [ID_W-1:0]           armor_id;
        logic                      prev_valid;
        logic [ID_W-1:0]           prev_id;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] chosen_index;
    } t_out_word;

endpackage

[rtl/target_window_selector_unit.sv]
// Top level of the target window selector.
// Depends on tws_pkg and on target_window_selector_unit_defines.svh.
//
// Usage: candidate plates of one set arrive as input words on a valid/ready
// channel, the first and last words of a set carrying their marks. Each word
// is captured in an input register; in the following cycle its delta
// (armor yaw minus center yaw, wrapping) is tested against the coming and
// leaving windows and its key is compared with the running best of the set.
// On a word marked last, one result word (found, chosen_index) is written to
// the output register; other words produce no result.
// A last word passes from the input register to the output register, which
// then holds its result. Throughput is one word per cycle, as long as a last
// word finds the output register free, set by the single window test and key
// compare between the input register and the result state.
// When the receiver stalls, the result stays in the output register; words
// without a last mark keep flowing, and a word with a last mark waits in the
// input register until the output register is free.
// Reset (synchronous, active low) empties both registers, clears the set
// state and outpost mode, and loads the window and margin registers with their defaults.
// Configuration writes take effect at once and are expected only while idle.
`include "target_window_selector_unit_defines.svh"

module target_window_selector_unit
    import tws_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data
);

    // Item counter saturates at the candidate limit, so it must hold the limit.
    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    // Full selection key: leaving penalty, |delta|, not-previous, id.
    localparam int KEY_W = 1 + ANGLE_W + 1 + ID_W;

    // Configuration registers.
    logic [WIN_W-1:0] r_coming;
    logic [WIN_W-1:0] r_leaving;
    logic [WIN_W-1:0] r_op_coming;
    logic [WIN_W-1:0] r_op_leaving;
    logic [WIN_W-1:0] r_margin;

    // Input register.
    logic     r_s_valid;
    t_in_word r_s;

    // Set state.
    logic [CNT_W-1:0]   r_count;
    logic               r_outpost;
    logic               r_best_valid;
    logic [KEY_W-1:0]   r_best_key;
    logic [POS_W-1:0]   r_best_pos;
    logic               r_held_valid;
    logic [POS_W-1:0]   r_held_pos;
    logic [ANGLE_W-1:0] r_held_abs;

    // Output register.
    logic      r_o_valid;
    t_out_word r_o;

    // Next values.
    logic [CNT_W-1:0]   n_count;
    logic               n_outpost;
    logic               n_best_valid;
    logic [KEY_W-1:0]   n_best_key;
    logic [POS_W-1:0]   n_best_pos;
    logic               n_held_valid;
    logic [POS_W-1:0]   n_held_pos;
    logic [ANGLE_W-1:0] n_held_abs;
    t_out_word          n_o;

    logic                      stage_go;
    logic                      out_free;
    logic [CNT_W-1:0]          eff_count;
    logic                      eff_best_valid;
    logic                      eff_held_valid;
    logic                      active;
    logic signed [ANGLE_W-1:0] delta;
    logic [ANGLE_W-1:0]        delta_mag;
    logic [WIN_W-1:0]          come;
    logic [WIN_W-1:0]          leave;
    logic                      in_come;
    logic                      in_leave;
    logic                      in_win;
    logic                      pen;
    logic                      is_prev;
    logic [KEY_W-1:0]          key;
    logic                      better;
    logic [POS_W-1:0]          pos;
    logic [ANGLE_W-1:0]        best_mag;
    logic signed [ANGLE_W+1:0] gain;

    // Handshake: a word without a last mark always moves on; a last word
    // needs room in the output register.
    assign out_free    = !r_o_valid || i_out_ready;
    assign stage_go    = r_s_valid && (!r_s.last_of_set || out_free);
    assign o_in_ready  = !r_s_valid || stage_go;
    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o;

    // A first mark starts from a cleared set.
    always_comb begin
        eff_count      = r_s.first_of_set ? '0 : r_count;
        eff_best_valid = r_s.first_of_set ? 1'b0 : r_best_valid;
        eff_held_valid = r_s.first_of_set ? 1'b0 : r_held_valid;
        n_outpost      = r_s.first_of_set ? r_s.outpost_flag : r_outpost;
    end

    assign active = eff_count < CNT_W'(MAX_CANDIDATES);
    assign pos    = POS_W'(eff_count);

    // Window test on the wrapped delta. The minus-pi delta has magnitude
    // 32768, which no 15-bit window can reach.
    always_comb begin
        delta     = r_s.plate_yaw - r_s.hub_yaw;
        delta_mag = delta[ANGLE_W-1] ? ANGLE_W'(-delta) : ANGLE_W'(delta);
        come      = n_outpost ? r_op_coming : r_coming;
        leave     = n_outpost ? r_op_leaving : r_leaving;
        in_come   = {1'b0, delta_mag} <= {2'b00, come};
        in_leave  = {1'b0, delta_mag} <= {2'b00, leave};
        case (r_s.spin_sign)
            SPIN_POS: begin
                in_win = in_come && (delta[ANGLE_W-1] || in_leave);
                pen    = !delta[ANGLE_W-1] && (delta != '0);
            end
            SPIN_NEG: begin
                in_win = in_come && (!delta[ANGLE_W-1] || in_leave);
                pen    = delta[ANGLE_W-1];
            end
            default: begin
                in_win = in_come;
                pen    = 1'b0;
            end
        endcase
        is_prev = r_s.prev_valid && (r_s.armor_id == r_s.prev_id);
        key     = {pen, delta_mag, !is_prev, r_s.armor_id};
        // Lexicographic order of the key fields is plain numeric order.
        better  = !eff_best_valid || (key < r_best_key);
    end

    always_comb begin
        n_count      = eff_count;
        n_best_valid = eff_best_valid;
        n_best_key   = r_best_key;
        n_best_pos   = r_best_pos;
        n_held_valid = eff_held_valid;
        n_held_pos   = r_held_pos;
        n_held_abs   = r_held_abs;
        if (active) begin
            n_count = eff_count + CNT_W'(1);
            if (in_win) begin
                if (is_prev) begin
                    n_held_valid = 1'b1;
                    n_held_pos   = pos;
                    n_held_abs   = delta_mag;
                end
                if (better) begin
                    n_best_valid = 1'b1;
                    n_best_key   = key;
                    n_best_pos   = pos;
                end
            end
        end
    end

    // Result: stay on the previous plate unless the best one gains enough.
    always_comb begin
        best_mag       = n_best_key[KEY_W-2 -: ANGLE_W];
        gain           = $signed({2'b00, n_held_abs}) - $signed({2'b00, best_mag});
        n_o.found      = n_best_valid;
        n_o.chosen_index = '0;
        if (n_best_valid) begin
            n_o.chosen_index = n_best_pos;
            if (n_held_valid && (n_held_pos != n_best_pos)
                    && (gain < $signed({3'b000, r_margin}))) begin
                n_o.chosen_index = n_held_pos;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coming     <= COMING_RST;
            r_leaving    <= LEAVING_RST;
            r_op_coming  <= OUTPOST_COMING_RST;
            r_op_leaving <= OUTPOST_LEAVING_RST;
            r_margin     <= SWITCH_MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COMING:          r_coming     <= i_cfg_data;
                CFG_LEAVING:         r_leaving    <= i_cfg_data;
                CFG_OUTPOST_COMING:  r_op_coming  <= i_cfg_data;
                CFG_OUTPOST_LEAVING: r_op_leaving <= i_cfg_data;
                CFG_SWITCH_MARGIN:   r_margin     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s <= i_in_word;
        end
    end

    // Set state; a last word clears it but keeps the outpost mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_outpost    <= 1'b0;
            r_best_valid <= 1'b0;
            r_held_valid <= 1'b0;
        end else if (stage_go) begin
            r_outpost <= n_outpost;
            if (r_s.last_of_set) begin
                r_count      <= '0;
                r_best_valid <= 1'b0;
                r_held_valid <= 1'b0;
            end else begin
                r_count      <= n_count;
                r_best_valid <= n_best_valid;
                r_held_valid <= n_held_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go) begin
            r_best_key <= n_best_key;
            r_best_pos <= n_best_pos;
            r_held_pos <= n_held_pos;
            r_held_abs <= n_held_abs;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (stage_go && r_s.last_of_set) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && r_s.last_of_set) begin
            r_o <= n_o;
        end
    end

    // Checks on the selection state.
    `TWS_ASSERT_IMPL(a_none_index_zero, r_o_valid && !r_o.found, r_o.chosen_index == '0, "index set without a found candidate")
    `TWS_ASSERT_ALWAYS(a_count_limit, r_count <= CNT_W'(MAX_CANDIDATES), "item count beyond limit")
    `TWS_ASSERT_IMPL(a_held_needs_best, r_held_valid, r_best_valid, "previous plate held without a best")
    `TWS_ASSERT_NEXT(a_clear_after_last, stage_go && r_s.last_of_set, (r_count == '0) && !r_best_valid && r_o_valid, "set not closed after last word")

endmodule
